// ===== hdl/sphere_point_camera_projector_core_defines.svh =====
// Assertion macros used by the projector top level.
`ifndef SPHERE_POINT_CAMERA_PROJECTOR_CORE_DEFINES_SVH
`define SPHERE_POINT_CAMERA_PROJECTOR_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define SPCP_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error("spcp check failed");
`define SPCP_ASSERT_NEXT(lbl, clk, rstn, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) else $error("spcp check failed");
`else
`define SPCP_ASSERT(lbl, clk, rstn, prop)
`define SPCP_ASSERT_NEXT(lbl, clk, rstn, pre, post)
`endif
`endif

// ===== hdl/spcp_pkg.sv =====
// Types and constants shared by the projector modules.
`timescale 1ns / 1ps
package spcp_pkg;

  localparam int QuoW = 21;
  localparam logic [QuoW-1:0] TermLimit = 21'd1048576;
  localparam logic signed [32:0] SentThresh = 33'sd2684354;
  localparam logic signed [18:0] SentPos = 19'sd160000;
  localparam logic signed [18:0] OutMax = 19'sd262143;
  localparam logic signed [18:0] OutMin = -19'sd262144;

  typedef enum logic [2:0] {
    REG_ROT_ROW0 = 3'd0,
    REG_ROT_ROW1 = 3'd1,
    REG_ROT_ROW2 = 3'd2,
    REG_FOCAL_X  = 3'd3,
    REG_FOCAL_Y  = 3'd4,
    REG_CENTER_X = 3'd5,
    REG_CENTER_Y = 3'd6
  } reg_idx_e;

  // Side information that travels with one axis through the divider.
  typedef struct packed {
    logic zpos;  // rotated z > 0
    logic neg;   // rotated component < 0
    logic sent;  // rotated component > 0.01
  } tag_t;

endpackage

// ===== hdl/spcp_rotate.sv =====
// Three-stage matrix rotation: products, row sums, magnitude and flags.
`timescale 1ns / 1ps
module spcp_rotate (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic signed [15:0]  sphere_x_i,
  input  logic signed [15:0]  sphere_y_i,
  input  logic signed [15:0]  sphere_z_i,
  input  logic [47:0]         rot_row0_i,
  input  logic [47:0]         rot_row1_i,
  input  logic [47:0]         rot_row2_i,
  output logic                valid_o,
  output logic [31:0]         mag_x_o,
  output spcp_pkg::tag_t      tag_x_o,
  output logic [31:0]         mag_y_o,
  output spcp_pkg::tag_t      tag_y_o,
  output logic [31:0]         depth_o
);
  import spcp_pkg::*;

  logic signed [31:0] prod_q [9];
  logic signed [32:0] sum_q [3];
  logic               v1_q, v2_q, v3_q;
  logic [31:0]        mag_x_q, mag_y_q, depth_q;
  tag_t               tag_x_q, tag_y_q;
  logic [47:0]        rows [3];
  logic signed [15:0] sv [3];

  assign rows[0] = rot_row0_i;
  assign rows[1] = rot_row1_i;
  assign rows[2] = rot_row2_i;
  assign sv[0]   = sphere_x_i;
  assign sv[1]   = sphere_y_i;
  assign sv[2]   = sphere_z_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // column 0 sits in the top 16 bits of a row
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int r = 0; r < 3; r++) begin
        prod_q[3*r]   <= $signed(rows[r][47:32]) * sv[0];
        prod_q[3*r+1] <= $signed(rows[r][31:16]) * sv[1];
        prod_q[3*r+2] <= $signed(rows[r][15:0])  * sv[2];
      end
      for (int r = 0; r < 3; r++) begin
        sum_q[r] <= 33'(prod_q[3*r]) + 33'(prod_q[3*r+1]) + 33'(prod_q[3*r+2]);
      end
      mag_x_q      <= sum_q[0][32] ? 32'(-sum_q[0]) : sum_q[0][31:0];
      mag_y_q      <= sum_q[1][32] ? 32'(-sum_q[1]) : sum_q[1][31:0];
      depth_q      <= sum_q[2][31:0];
      tag_x_q.zpos <= !sum_q[2][32] && (|sum_q[2]);
      tag_x_q.neg  <= sum_q[0][32];
      tag_x_q.sent <= sum_q[0] > SentThresh;
      tag_y_q.zpos <= !sum_q[2][32] && (|sum_q[2]);
      tag_y_q.neg  <= sum_q[1][32];
      tag_y_q.sent <= sum_q[1] > SentThresh;
    end
  end

  assign valid_o = v3_q;
  assign mag_x_o = mag_x_q;
  assign mag_y_o = mag_y_q;
  assign tag_x_o = tag_x_q;
  assign tag_y_o = tag_y_q;
  assign depth_o = depth_q;

endmodule

// ===== hdl/spcp_divider.sv =====
// Pipelined focal multiply and rounded restoring divide, one quotient bit per stage.
`timescale 1ns / 1ps
module spcp_divider (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic [31:0]                 mag_i,
  input  logic [15:0]                 focal_i,
  input  logic [31:0]                 den_i,
  input  spcp_pkg::tag_t              tag_i,
  output logic                        valid_o,
  output logic [spcp_pkg::QuoW-1:0]   quo_o,
  output spcp_pkg::tag_t              tag_o
);
  import spcp_pkg::*;

  logic        vm_q, vp_q;
  logic [47:0] num_q;
  logic [48:0] n_q;
  logic [31:0] denm_q, denp_q;
  tag_t        tagm_q, tagp_q;

  logic            v_q   [0:QuoW];
  logic [52:0]     rem_q [0:QuoW];
  logic [31:0]     den_q [0:QuoW];
  logic [QuoW-1:0] quo_q [0:QuoW];
  logic            ovf_q [0:QuoW];
  tag_t            tag_q [0:QuoW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vm_q <= 1'b0;
      vp_q <= 1'b0;
      v_q[0] <= 1'b0;
    end else if (en_i) begin
      vm_q <= valid_i;
      vp_q <= vm_q;
      v_q[0] <= vp_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_q    <= mag_i * focal_i;
      denm_q   <= den_i;
      tagm_q   <= tag_i;
      // add half the divisor for round-to-nearest
      n_q      <= {1'b0, num_q} + 49'(denm_q >> 1);
      denp_q   <= denm_q;
      tagp_q   <= tagm_q;
      rem_q[0] <= 53'(n_q);
      den_q[0] <= denp_q;
      tag_q[0] <= tagp_q;
      quo_q[0] <= '0;
      ovf_q[0] <= {4'b0, n_q[48:21]} >= denp_q;
    end
  end

  for (genvar i = 0; i < QuoW; i++) begin : g_bit
    logic [52:0] sub;
    logic        ge;
    assign sub = 53'(den_q[i]) << (QuoW - 1 - i);
    assign ge  = rem_q[i] >= sub;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i+1] <= 1'b0;
      end else if (en_i) begin
        v_q[i+1] <= v_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i+1] <= ge ? rem_q[i] - sub : rem_q[i];
        quo_q[i+1] <= {quo_q[i][QuoW-2:0], ge};
        den_q[i+1] <= den_q[i];
        ovf_q[i+1] <= ovf_q[i];
        tag_q[i+1] <= tag_q[i];
      end
    end
  end

  assign valid_o = v_q[QuoW];
  assign quo_o   = (ovf_q[QuoW] || quo_q[QuoW] > TermLimit) ? TermLimit : quo_q[QuoW];
  assign tag_o   = tag_q[QuoW];

endmodule

// ===== hdl/spcp_finish.sv =====
// Principal point add, clamp, rectangle test and sentinel select.
`timescale 1ns / 1ps
module spcp_finish (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  logic [spcp_pkg::QuoW-1:0]  quo_x_i,
  input  spcp_pkg::tag_t             tag_x_i,
  input  logic [spcp_pkg::QuoW-1:0]  quo_y_i,
  input  spcp_pkg::tag_t             tag_y_i,
  input  logic [15:0]                center_x_i,
  input  logic [15:0]                center_y_i,
  output logic                       valid_o,
  output logic signed [18:0]         map_x_o,
  output logic signed [18:0]         map_y_o,
  output logic                       in_view_o
);
  import spcp_pkg::*;

  function automatic logic signed [18:0] place(logic [QuoW-1:0] q, logic neg,
                                               logic [15:0] c);
    logic signed [21:0] t;
    logic signed [21:0] s;
    t = neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
    s = t + $signed({6'b0, c});
    if (s > 22'(OutMax)) return OutMax;
    if (s < 22'(OutMin)) return OutMin;
    return s[18:0];
  endfunction

  // pixel = floor((m + 8) / 16), limit = floor(2 * c / 16)
  function automatic logic in_rect(logic signed [18:0] m, logic [15:0] c);
    logic signed [19:0] t;
    t = 20'(m) + 20'sd8;
    return !t[19] && (t[18:4] < 15'(c[15:3]));
  endfunction

  logic               v1_q, v2_q;
  logic signed [18:0] mx_q, my_q, map_x_q, map_y_q;
  tag_t               tx_q, ty_q;
  logic               in_view_q;
  logic               ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  assign ok = tx_q.zpos && in_rect(mx_q, center_x_i) && in_rect(my_q, center_y_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mx_q      <= place(quo_x_i, tag_x_i.neg, center_x_i);
      my_q      <= place(quo_y_i, tag_y_i.neg, center_y_i);
      tx_q      <= tag_x_i;
      ty_q      <= tag_y_i;
      in_view_q <= ok;
      map_x_q   <= ok ? mx_q : (tx_q.sent ? SentPos : -SentPos);
      map_y_q   <= ok ? my_q : (ty_q.sent ? SentPos : -SentPos);
    end
  end

  assign valid_o   = v2_q;
  assign map_x_o   = map_x_q;
  assign map_y_o   = map_y_q;
  assign in_view_o = in_view_q;

endmodule

// ===== hdl/sphere_point_camera_projector_core.sv =====
// Projector top level: config registers, pipeline and stream ports.
`timescale 1ns / 1ps
// Rotates each unit-sphere point by the configured matrix and projects it
// through a pinhole camera, one point per clock while the output is not
// stalled. The pipeline runs the rotation, the focal multiply and divide
// setup, the bit-per-stage divider that forms the rounded quotient, and
// placement, the rectangle test and the output register. The whole pipeline
// advances while the output beat is taken or the output register is empty;
// a stall on the output side holds every stage. Write configuration only
// while no point is in flight.
module sphere_point_camera_projector_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // sphere_x [15:0], sphere_y [31:16], sphere_z [47:32]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // map_x [18:0], map_y [37:19], zero [39:38]
  output logic        m_axis_tuser,   // in_view
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [47:0] cfg_data_i
);
  import spcp_pkg::*;
  `include "sphere_point_camera_projector_core_defines.svh"

  logic [47:0] rot_row0_q, rot_row1_q, rot_row2_q;
  logic [15:0] focal_x_q, focal_y_q, center_x_q, center_y_q;
  logic        en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rot_row0_q <= 48'h4000_0000_0000;
      rot_row1_q <= 48'h0000_4000_0000;
      rot_row2_q <= 48'h0000_0000_4000;
      focal_x_q  <= 16'd8192;
      focal_y_q  <= 16'd8192;
      center_x_q <= 16'd5120;
      center_y_q <= 16'd3840;
    end else if (cfg_valid_i) begin
      unique case (reg_idx_e'(cfg_index_i))
        REG_ROT_ROW0: rot_row0_q <= cfg_data_i;
        REG_ROT_ROW1: rot_row1_q <= cfg_data_i;
        REG_ROT_ROW2: rot_row2_q <= cfg_data_i;
        REG_FOCAL_X:  focal_x_q  <= cfg_data_i[15:0];
        REG_FOCAL_Y:  focal_y_q  <= cfg_data_i[15:0];
        REG_CENTER_X: center_x_q <= cfg_data_i[15:0];
        REG_CENTER_Y: center_y_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;

  logic               rv;
  logic [31:0]        mag_x, mag_y, depth;
  tag_t               rtag_x, rtag_y, dtag_x, dtag_y;
  logic               dv_x, dv_y;
  logic [QuoW-1:0]    quo_x, quo_y;
  logic               fv;
  logic signed [18:0] map_x, map_y;
  logic               in_view;
  logic               sent_x, sent_y;

  // advance when the output beat is taken or the output slot is empty
  assign en            = m_axis_tready || !fv;
  assign s_axis_tready = en;

  spcp_rotate u_rotate (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (s_axis_tvalid),
    .sphere_x_i (s_axis_tdata[15:0]),
    .sphere_y_i (s_axis_tdata[31:16]),
    .sphere_z_i (s_axis_tdata[47:32]),
    .rot_row0_i (rot_row0_q),
    .rot_row1_i (rot_row1_q),
    .rot_row2_i (rot_row2_q),
    .valid_o    (rv),
    .mag_x_o    (mag_x),
    .tag_x_o    (rtag_x),
    .mag_y_o    (mag_y),
    .tag_y_o    (rtag_y),
    .depth_o    (depth)
  );

  spcp_divider u_div_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (rv),
    .mag_i   (mag_x),
    .focal_i (focal_x_q),
    .den_i   (depth),
    .tag_i   (rtag_x),
    .valid_o (dv_x),
    .quo_o   (quo_x),
    .tag_o   (dtag_x)
  );

  spcp_divider u_div_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (rv),
    .mag_i   (mag_y),
    .focal_i (focal_y_q),
    .den_i   (depth),
    .tag_i   (rtag_y),
    .valid_o (dv_y),
    .quo_o   (quo_y),
    .tag_o   (dtag_y)
  );

  spcp_finish u_finish (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (dv_x),
    .quo_x_i    (quo_x),
    .tag_x_i    (dtag_x),
    .quo_y_i    (quo_y),
    .tag_y_i    (dtag_y),
    .center_x_i (center_x_q),
    .center_y_i (center_y_q),
    .valid_o    (fv),
    .map_x_o    (map_x),
    .map_y_o    (map_y),
    .in_view_o  (in_view)
  );

  assign m_axis_tvalid = fv;
  assign m_axis_tdata  = {2'b00, map_y, map_x};
  assign m_axis_tuser  = in_view;

  assign sent_x = (map_x == SentPos) || (map_x == -SentPos);
  assign sent_y = (map_y == SentPos) || (map_y == -SentPos);

  // a pixel-rounded coordinate of zero allows a map value down to -8
  `SPCP_ASSERT(a_lanes_aligned, clk_i, rst_ni, dv_x == dv_y)
  `SPCP_ASSERT(a_view_range, clk_i, rst_ni, (fv && in_view) |-> (map_x >= -19'sd8 && map_y >= -19'sd8))
  `SPCP_ASSERT(a_sentinel, clk_i, rst_ni, (fv && !in_view) |-> (sent_x && sent_y))
  `SPCP_ASSERT_NEXT(a_hold_on_stall, clk_i, rst_ni, fv && !m_axis_tready, fv && $stable(in_view))

endmodule

// ===== test/sphere_point_camera_projector_core_test.sv =====
// Self-checking stream testbench for the sphere point camera projector core.
`timescale 1ns / 1ps
module sphere_point_camera_projector_core_test;
  import spcp_pkg::*;

  typedef struct {
    logic [18:0] map_x;
    logic [18:0] map_y;
    logic        in_view;
  } proj_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [47:0] cfg_data_i = '0;

  sphere_point_camera_projector_core i_dut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  always #5 clk_i = ~clk_i;

  // Shadow copy of the camera registers.
  logic [47:0] rot_q [3];
  logic [15:0] fx_q, fy_q, cx_q, cy_q;

  logic [47:0] point_queue [$];
  proj_t       proj_queue [$];
  int          errors = 0;
  int          n_checked = 0;
  int          n_in_view = 0;
  bit          calm = 1'b0;     // no idling in the last part
  bit          hold_out = 1'b0; // long receiver hold-off
  int          src_gap = 0;
  int          sink_gap = 0;

  function automatic longint signed coef(logic [47:0] row, int col);
    logic signed [15:0] c;
    c = row[47 - 16 * col -: 16];
    return c;
  endfunction

  function automatic longint signed focal_term(logic [15:0] f, longint signed r,
                                               longint signed d);
    longint unsigned mag, q;
    mag = (r < 0) ? -r : r;
    q = (mag * f + d / 2) / d;
    if (q > 1048576) q = 1048576;
    return (r < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic bit in_rect(longint signed m, logic [15:0] c);
    longint signed lim, t;
    lim = ({16'd0, c} * 2) >> 4;
    t = m + 8;
    if (t < 0) return 1'b0;
    return (t >>> 4) < lim;
  endfunction

  function automatic longint signed clamp_out(longint signed v);
    if (v < -262144) return -262144;
    if (v > 262143) return 262143;
    return v;
  endfunction

  function automatic proj_t project_point(logic [47:0] p);
    longint signed s [3], r [3], mx, my;
    logic signed [15:0] t;
    proj_t o;
    bit ok;
    for (int i = 0; i < 3; i++) begin
      t = p[16 * i +: 16];
      s[i] = t;
    end
    for (int i = 0; i < 3; i++) begin
      r[i] = 0;
      for (int j = 0; j < 3; j++) r[i] += coef(rot_q[i], j) * s[j];
    end
    ok = 1'b0;
    mx = 0;
    my = 0;
    if (r[2] > 0) begin
      mx = clamp_out(focal_term(fx_q, r[0], r[2]) + cx_q);
      my = clamp_out(focal_term(fy_q, r[1], r[2]) + cy_q);
      ok = in_rect(mx, cx_q) && in_rect(my, cy_q);
    end
    if (!ok) begin
      mx = (r[0] > 2684354) ? 160000 : -160000;
      my = (r[1] > 2684354) ? 160000 : -160000;
    end
    o.map_x = mx[18:0];
    o.map_y = my[18:0];
    o.in_view = ok;
    return o;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0h want %0h (result %0d)", what, got, want, n_checked);
    errors++;
  endtask

  task automatic add_point(logic [47:0] p);
    point_queue = {point_queue, p};
  endtask

  // Driver: offer queued points, with random gaps.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        proj_queue = {proj_queue, project_point(s_axis_tdata)};
        void'(point_queue.pop_front());
      end
      if (src_gap > 0) begin
        src_gap <= src_gap - 1;
        s_axis_tvalid <= 1'b0;
      end else if (!calm && !(s_axis_tvalid && !s_axis_tready) &&
                   $urandom_range(0, 9) == 0) begin
        // idle only between beats, never while one waits
        src_gap <= $urandom_range(1, 16);
        s_axis_tvalid <= 1'b0;
      end else begin
        if (s_axis_tvalid && s_axis_tready) begin
          if (point_queue.size() > 0) begin
            s_axis_tvalid <= 1'b1;
            s_axis_tdata <= point_queue[0];
          end else s_axis_tvalid <= 1'b0;
        end else if (point_queue.size() > 0) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= point_queue[0];
        end else s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Monitor: check each output beat, stall at random.
  always @(posedge clk_i) begin
    proj_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (proj_queue.size() == 0) begin
          report_mismatch("unexpected beat", m_axis_tdata, 0);
        end else begin
          want = proj_queue.pop_front();
          if (m_axis_tdata[18:0] !== want.map_x)
            report_mismatch("map_x", m_axis_tdata[18:0], want.map_x);
          if (m_axis_tdata[37:19] !== want.map_y)
            report_mismatch("map_y", m_axis_tdata[37:19], want.map_y);
          if (m_axis_tuser !== want.in_view)
            report_mismatch("in_view", m_axis_tuser, want.in_view);
          if (want.in_view) n_in_view++;
        end
        n_checked++;
      end
      if (hold_out) m_axis_tready <= 1'b0;
      else if (sink_gap > 0) begin
        sink_gap <= sink_gap - 1;
        m_axis_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        sink_gap <= $urandom_range(1, 16);
        m_axis_tready <= 1'b0;
      end else m_axis_tready <= 1'b1;
    end
  end

  task automatic write_reg(reg_idx_e idx, logic [47:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_ROT_ROW0: rot_q[0] = val;
      REG_ROT_ROW1: rot_q[1] = val;
      REG_ROT_ROW2: rot_q[2] = val;
      REG_FOCAL_X:  fx_q = val[15:0];
      REG_FOCAL_Y:  fy_q = val[15:0];
      REG_CENTER_X: cx_q = val[15:0];
      default:      cy_q = val[15:0];
    endcase
  endtask

  task automatic drain;
    wait (point_queue.size() == 0 && !s_axis_tvalid && proj_queue.size() == 0);
    repeat (40) @(posedge clk_i);
  endtask

  function automatic logic [15:0] unit_comp();
    int k;
    k = $urandom_range(0, 15);
    if (k == 0) return 16'($urandom());  // any pattern, -32768 included
    if (k == 1) return 16'(16384);
    if (k == 2) return -16'sd16384;
    return 16'($signed($urandom_range(0, 32768)) - 16384);
  endfunction

  // Point aimed roughly at +z so that most land in view.
  function automatic logic [47:0] forward_point();
    logic signed [15:0] x, y, z;
    x = 16'($signed($urandom_range(0, 8000)) - 4000);
    y = 16'($signed($urandom_range(0, 8000)) - 4000);
    z = 16'($urandom_range(9000, 16384));
    return {z, y, x};
  endfunction

  function automatic logic [47:0] rot_row(int sel, int axis);
    logic signed [15:0] c [3];
    for (int j = 0; j < 3; j++) c[j] = (j == axis) ? 16'sd16384 : 16'sd0;
    if (sel == 1) for (int j = 0; j < 3; j++) c[j] = 16'($urandom());
    if (sel == 2) for (int j = 0; j < 3; j++)
      c[j] = (j == axis) ? 16'($urandom_range(14000, 16384))
                         : 16'($signed($urandom_range(0, 6000)) - 3000);
    return {c[0], c[1], c[2]};
  endfunction

  task automatic load_camera(int sel);
    write_reg(REG_ROT_ROW0, rot_row(sel, 0));
    write_reg(REG_ROT_ROW1, rot_row(sel, 1));
    write_reg(REG_ROT_ROW2, rot_row(sel, 2));
    case (sel)
      0: begin
        write_reg(REG_FOCAL_X, 48'd8192); write_reg(REG_FOCAL_Y, 48'd8192);
        write_reg(REG_CENTER_X, 48'd5120); write_reg(REG_CENTER_Y, 48'd3840);
      end
      3: begin
        write_reg(REG_FOCAL_X, 48'hffff); write_reg(REG_FOCAL_Y, 48'hffff);
        write_reg(REG_CENTER_X, 48'hffff); write_reg(REG_CENTER_Y, 48'hffff);
      end
      4: begin
        write_reg(REG_FOCAL_X, 48'd0); write_reg(REG_FOCAL_Y, 48'd1);
        write_reg(REG_CENTER_X, 48'd0); write_reg(REG_CENTER_Y, 48'd7);
      end
      default: begin
        write_reg(REG_FOCAL_X, 48'($urandom_range(1, 65535)));
        write_reg(REG_FOCAL_Y, 48'($urandom_range(1, 65535)));
        write_reg(REG_CENTER_X, 48'($urandom_range(0, 65535)));
        write_reg(REG_CENTER_Y, 48'($urandom_range(0, 65535)));
      end
    endcase
  endtask

  initial begin
    rot_q[0] = 48'd70368744177664;
    rot_q[1] = 48'd1073741824;
    rot_q[2] = 48'd16384;
    fx_q = 16'd8192; fy_q = 16'd8192; cx_q = 16'd5120; cy_q = 16'd3840;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: extremes, center, behind camera, zero depth, off-threshold.
    add_point({16'sd16384, 16'sd0, 16'sd0});
    add_point({-16'sd16384, 16'sd0, 16'sd0});
    add_point({16'sd0, 16'sd16384, 16'sd0});
    add_point({16'sd0, 16'sd0, 16'sd16384});
    add_point({16'sd0, -16'sd16384, -16'sd16384});
    add_point({16'h8000, 16'h8000, 16'h8000});
    add_point({16'h7fff, 16'h7fff, 16'h7fff});
    add_point({16'sd1, 16'sd1, 16'sd1});
    add_point({16'sd1, -16'sd16384, 16'sd16384});
    add_point({16'sd16384, 16'sd1, 16'sd16384});
    add_point({16'sd0, 16'sd164, 16'sd164});
    add_point({16'sd0, 16'sd163, 16'sd163});
    add_point({16'sd16384, 16'sd10240, 16'sd7680});
    add_point({16'sd16384, 16'sd7500, 16'sd10000});
    add_point({16'sd16384, -16'sd7500, -16'sd10000});
    add_point({16'hffff, 16'hffff, 16'hffff});
    drain();

    for (int phase = 0; phase < 8; phase++) begin
      load_camera(phase == 7 ? 0 : (phase < 5 ? phase : 2));
      if (phase == 1) begin
        // Hold the output off while input keeps flowing.
        hold_out = 1'b1;
        repeat (60) add_point(forward_point());
        repeat (200) @(posedge clk_i);
        hold_out = 1'b0;
      end
      if (phase == 7) calm = 1'b1;
      repeat (200) add_point(($urandom_range(0, 3) == 0) ?
        {unit_comp(), unit_comp(), unit_comp()} : forward_point());
      drain();
    end

    $display("checked %0d projected points, %0d in view, over 8 camera settings",
             n_checked, n_in_view);
    if (errors == 0) $display("sphere_point_camera_projector_core_test: PASS");
    else $display("sphere_point_camera_projector_core_test: FAIL");
    $finish;
  end

  initial begin
    #5ms;
    $display("sphere_point_camera_projector_core_test: FAIL");
    $finish;
  end
endmodule

// ===== files.f =====
+incdir+hdl
hdl/spcp_pkg.sv
hdl/spcp_rotate.sv
hdl/spcp_divider.sv
hdl/spcp_finish.sv
hdl/sphere_point_camera_projector_core.sv
test/sphere_point_camera_projector_core_test.sv
